// ===== hw/rtl/point_mass_motion_step_macros.svh =====
// Assertion macros for the point mass motion step checker.
// No dependencies.
`ifndef POINT_MASS_MOTION_STEP_MACROS_SVH
`define POINT_MASS_MOTION_STEP_MACROS_SVH
`define PMS_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("%m: label failed");
`define PMS_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("%m: label failed");
`endif

// ===== hw/rtl/pms_pkg.sv =====
// Package for the point mass motion step: commands, register indexes, command structs.
// No dependencies.
package pms_pkg;
  localparam int FRAC_BITS = 16;
  localparam int ONE = 1 << FRAC_BITS;

  typedef enum logic [2:0] {
    CMD_TICK = 3'd0, CMD_FORCE = 3'd1, CMD_IMPULSE = 3'd2, CMD_VEL = 3'd3,
    CMD_ACCEL = 3'd4, CMD_COLLIDE = 3'd5, CMD_SLEEP = 3'd6, CMD_WAKE = 3'd7
  } cmd_t;

  localparam logic [2:0] REG_DRAG = 3'd0;
  localparam logic [2:0] REG_FRICTION = 3'd1;
  localparam logic [2:0] REG_BOUNCE = 3'd2;
  localparam logic [2:0] REG_MASS = 3'd3;
  localparam logic [2:0] REG_DT = 3'd4;
  localparam logic [2:0] REG_THR = 3'd5;

  // datapath micro-ops
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_TICK_DRAG, OP_TICK_REST, OP_TICK_POS, OP_FORCE_MUL,
    OP_DIV_START, OP_DIV_STEP, OP_FORCE_ADD, OP_VEL_ADD, OP_COL_PUSH,
    OP_COL_DOT, OP_COL_PROJ, OP_COL_VEL, OP_SET_SLEEP, OP_CLR_SLEEP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       axis;
  } dp_cmd_t;

  typedef struct packed {
    logic       asleep;
    logic       push_small;
    logic       div_done;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return 32'sh7fffffff;
    if (v < -68'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

// ===== hw/rtl/point_mass_motion_step.sv =====
// Point mass motion step: one command word in, one state word out.
// Input word: command, vec_x, vec_y. Output word: pos, vel, asleep.
// Six registers on an APB port: drag, friction, bounce, mass, delta_time,
// rest_threshold at byte addresses 0..20.
// One word is processed at a time; in_tready is high only when idle.
// Steps from input accept to output: tick applies drag, rest check and
// position update; velocity change/acceleration/sleep/wake and commands
// ignored while asleep go straight to output; collide pushes, then runs an
// 80-step restoring divide of dot product by squared push length, skipped
// when the push is below the rest threshold; force and impulse run two
// 64-step divides by mass, one per axis. The next word can be accepted in
// the cycle after the result is taken, and not before.
// The result stays on out_tdata with out_tvalid high until taken; a stalled
// receiver holds the block. Reset clears position, velocity and sleep flag
// and loads the register defaults.
// Depends on pms_pkg, pms_ctrl, pms_datapath.
module point_mass_motion_step (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // command[2:0], vec_x[34:3], vec_y[66:35]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // pos_x, pos_y, vel_x, vel_y
  output logic         out_tuser,  // asleep
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  logic [16:0] drag_r, fric_r, dt_r, thr_r;
  logic [17:0] bounce_r;
  logic [30:0] mass_r;
  pms_pkg::dp_cmd_t cmd;
  pms_pkg::dp_status_t status;
  logic signed [31:0] px, py, vx, vy;
  logic [2:0] ridx;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drag_r <= 17'd655; fric_r <= 17'd655; bounce_r <= 18'd65536;
      mass_r <= 31'd65536; dt_r <= 17'd1092; thr_r <= 17'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (ridx)
        pms_pkg::REG_DRAG: drag_r <= cfg_pwdata[16:0];
        pms_pkg::REG_FRICTION: fric_r <= cfg_pwdata[16:0];
        pms_pkg::REG_BOUNCE: bounce_r <= cfg_pwdata[17:0];
        pms_pkg::REG_MASS: mass_r <= cfg_pwdata[30:0];
        pms_pkg::REG_DT: dt_r <= cfg_pwdata[16:0];
        pms_pkg::REG_THR: thr_r <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      pms_pkg::REG_DRAG: cfg_prdata = {15'd0, drag_r};
      pms_pkg::REG_FRICTION: cfg_prdata = {15'd0, fric_r};
      pms_pkg::REG_BOUNCE: cfg_prdata = {14'd0, bounce_r};
      pms_pkg::REG_MASS: cfg_prdata = {1'b0, mass_r};
      pms_pkg::REG_DT: cfg_prdata = {15'd0, dt_r};
      pms_pkg::REG_THR: cfg_prdata = {15'd0, thr_r};
      default: cfg_prdata = '0;
    endcase
  end

  pms_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready),
    .in_cmd(in_tdata[2:0]), .out_tready(out_tready), .status(status),
    .in_tready(in_tready), .out_tvalid(out_tvalid), .cmd(cmd)
  );

  pms_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .vec_x(in_tdata[34:3]),
    .vec_y(in_tdata[66:35]), .drag(drag_r), .friction(fric_r),
    .bounce(bounce_r), .mass(mass_r), .delta_time(dt_r),
    .rest_threshold(thr_r), .status(status),
    .pos_x(px), .pos_y(py), .vel_x(vx), .vel_y(vy)
  );

  assign out_tdata = {vy, vx, py, px};
  assign out_tuser = status.asleep;
endmodule

// ===== hw/rtl/pms_datapath.sv =====
// Datapath for the point mass motion step: state registers, parallel multipliers,
// a shared restoring divider. Depends on pms_pkg.
module pms_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pms_pkg::dp_cmd_t     cmd,
  input  logic [31:0]          vec_x,
  input  logic [31:0]          vec_y,
  input  logic [16:0]          drag,
  input  logic [16:0]          friction,
  input  logic [17:0]          bounce,
  input  logic [30:0]          mass,
  input  logic [16:0]          delta_time,
  input  logic [16:0]          rest_threshold,
  output pms_pkg::dp_status_t  status,
  output logic signed [31:0]   pos_x,
  output logic signed [31:0]   pos_y,
  output logic signed [31:0]   vel_x,
  output logic signed [31:0]   vel_y
);
  logic signed [31:0] px_r, py_r, vx_r, vy_r, ix_r, iy_r;
  logic               sleep_r;
  logic signed [49:0] prx_r, pry_r;
  logic [63:0]        num_r, rem_r, den_r, quo_r;
  logic               neg_r;
  logic [6:0]         cnt_r;
  logic               small_r;
  logic signed [49:0] k_r;

  logic signed [17:0] fd, ff;
  logic signed [49:0] mulx, muly;
  logic [63:0]        sx, sy, thr2, pp;
  logic signed [64:0] dot;
  logic [64:0]        rsh;
  logic               qbit;
  logic [63:0]        qn;
  logic signed [32:0] mass_s;
  logic signed [34:0] tx, ty;

  assign fd = (drag > 17'(pms_pkg::ONE)) ? 18'sd0 : 18'(pms_pkg::ONE) - 18'(drag);
  assign ff = (friction > 17'(pms_pkg::ONE)) ? 18'sd0 :
              18'(pms_pkg::ONE) - 18'(friction);
  assign sx = 64'(vx_r * vx_r);
  assign sy = 64'(vy_r * vy_r);
  assign pp = 64'(ix_r * ix_r) + 64'(iy_r * iy_r);
  assign thr2 = 64'(rest_threshold) * 64'(rest_threshold);
  assign dot = 65'(vx_r * ix_r) + 65'(vy_r * iy_r);
  assign rsh = {rem_r, num_r[63]};
  assign qbit = (rsh >= {1'b0, den_r});
  assign qn = {quo_r[62:0], qbit};
  assign mass_s = (mass == 31'd0) ? 33'sd1 : $signed({2'b00, mass});
  assign tx = 35'(vx_r) - 35'($signed(prx_r[33:0]));
  assign ty = 35'(vy_r) - 35'($signed(pry_r[33:0]));
  assign mulx = 50'(vx_r * fd);
  assign muly = 50'(vy_r * fd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0; py_r <= '0; vx_r <= '0; vy_r <= '0;
      sleep_r <= 1'b0; cnt_r <= '0; small_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        pms_pkg::OP_LOAD: begin
          ix_r <= vec_x; iy_r <= vec_y;
        end
        pms_pkg::OP_TICK_DRAG: begin
          vx_r <= mulx[47:16]; vy_r <= muly[47:16];
        end
        pms_pkg::OP_TICK_REST: if (sx + sy < thr2) begin
          vx_r <= '0; vy_r <= '0;
        end
        pms_pkg::OP_TICK_POS: begin
          px_r <= pms_pkg::sat32(68'(px_r) + 68'((vx_r * $signed({1'b0, delta_time})) >>> 16));
          py_r <= pms_pkg::sat32(68'(py_r) + 68'((vy_r * $signed({1'b0, delta_time})) >>> 16));
        end
        pms_pkg::OP_FORCE_MUL: begin
          prx_r <= 50'((cmd.axis ? iy_r : ix_r) * $signed({1'b0, delta_time}));
        end
        pms_pkg::OP_DIV_START: begin
          neg_r <= prx_r[49] ^ 1'b0;
          num_r <= prx_r[49] ? 64'(-prx_r) : 64'(prx_r);
          den_r <= 64'(mass_s);
          rem_r <= '0; quo_r <= '0; cnt_r <= 7'd64;
        end
        pms_pkg::OP_COL_DOT: begin
          neg_r <= dot[64];
          num_r <= (dot[64] ? 64'(-dot) : 64'(dot)) ;
          den_r <= pp; rem_r <= '0; quo_r <= '0; cnt_r <= 7'd80;
        end
        pms_pkg::OP_DIV_STEP: begin
          if (qbit) begin
            rem_r <= 64'(rsh - {1'b0, den_r});
          end else begin
            rem_r <= rsh[63:0];
          end
          quo_r <= qn;
          num_r <= {num_r[62:0], 1'b0};
          cnt_r <= cnt_r - 7'd1;
          // signed projection factor, magnitude below 2^48
          if (cnt_r == 7'd1) begin
            k_r <= neg_r ? -$signed({2'b00, qn[47:0]}) : $signed({2'b00, qn[47:0]});
          end
        end
        pms_pkg::OP_FORCE_ADD: begin
          if (cmd.axis)
            vy_r <= pms_pkg::sat32(68'(vy_r) + (neg_r ? -68'(quo_r) : 68'(quo_r)));
          else
            vx_r <= pms_pkg::sat32(68'(vx_r) + (neg_r ? -68'(quo_r) : 68'(quo_r)));
        end
        pms_pkg::OP_VEL_ADD: begin
          vx_r <= pms_pkg::sat32(68'(vx_r) + 68'((ix_r * $signed({1'b0, delta_time})) >>> 16));
          vy_r <= pms_pkg::sat32(68'(vy_r) + 68'((iy_r * $signed({1'b0, delta_time})) >>> 16));
        end
        pms_pkg::OP_COL_PUSH: begin
          px_r <= pms_pkg::sat32(68'(px_r) + 68'(ix_r));
          py_r <= pms_pkg::sat32(68'(py_r) + 68'(iy_r));
          small_r <= (pp == 64'd0) || (pp < thr2);
        end
        pms_pkg::OP_COL_PROJ: begin
          // floor(k * push / one) as high part times push plus floored low part
          prx_r <= 50'($signed(k_r[49:16]) * ix_r +
                       (($signed({1'b0, k_r[15:0]}) * ix_r) >>> 16));
          pry_r <= 50'($signed(k_r[49:16]) * iy_r +
                       (($signed({1'b0, k_r[15:0]}) * iy_r) >>> 16));
        end
        pms_pkg::OP_COL_VEL: begin
          vx_r <= pms_pkg::sat32(68'((tx * ff) >>> 16) -
                  68'(($signed(prx_r[33:0]) * $signed({1'b0, bounce})) >>> 16));
          vy_r <= pms_pkg::sat32(68'((ty * ff) >>> 16) -
                  68'(($signed(pry_r[33:0]) * $signed({1'b0, bounce})) >>> 16));
        end
        pms_pkg::OP_SET_SLEEP: sleep_r <= 1'b1;
        pms_pkg::OP_CLR_SLEEP: sleep_r <= 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    status.asleep = sleep_r;
    status.push_small = small_r;
    status.div_done = (cnt_r == 7'd0) ||
                      ((cmd.op == pms_pkg::OP_DIV_STEP) && (cnt_r == 7'd1));
  end
  assign pos_x = px_r;
  assign pos_y = py_r;
  assign vel_x = vx_r;
  assign vel_y = vy_r;
endmodule

// ===== hw/rtl/pms_ctrl.sv =====
// Sequencer for the point mass motion step: handshakes and micro-op order.
// Depends on pms_pkg.
module pms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [2:0]          in_cmd,
  input  logic                out_tready,
  input  pms_pkg::dp_status_t status,
  output logic                in_tready,
  output logic                out_tvalid,
  output pms_pkg::dp_cmd_t    cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_T1, S_T2, S_F0, S_FS, S_FD, S_FA,
    S_C1, S_CD, S_CW, S_CP, S_CV, S_OUT
  } state_t;
  state_t state_r, state_nxt;
  logic [2:0] c_r;
  logic axis_r, axis_nxt;

  always_comb begin
    state_nxt = state_r;
    axis_nxt = axis_r;
    cmd.op = pms_pkg::OP_NONE;
    cmd.axis = axis_r;
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.op = pms_pkg::OP_LOAD;
        state_nxt = S_DISPATCH;
        axis_nxt = 1'b0;
      end
      S_DISPATCH: begin
        unique case (c_r)
          pms_pkg::CMD_TICK: if (status.asleep) state_nxt = S_OUT;
            else begin cmd.op = pms_pkg::OP_TICK_DRAG; state_nxt = S_T1; end
          pms_pkg::CMD_FORCE, pms_pkg::CMD_IMPULSE: state_nxt = S_F0;
          pms_pkg::CMD_VEL: begin cmd.op = pms_pkg::OP_VEL_ADD; state_nxt = S_OUT; end
          pms_pkg::CMD_COLLIDE: if (status.asleep) state_nxt = S_OUT;
            else begin cmd.op = pms_pkg::OP_COL_PUSH; state_nxt = S_C1; end
          pms_pkg::CMD_SLEEP: begin cmd.op = pms_pkg::OP_SET_SLEEP; state_nxt = S_OUT; end
          pms_pkg::CMD_WAKE: begin cmd.op = pms_pkg::OP_CLR_SLEEP; state_nxt = S_OUT; end
          default: state_nxt = S_OUT;
        endcase
      end
      S_T1: begin cmd.op = pms_pkg::OP_TICK_REST; state_nxt = S_T2; end
      S_T2: begin cmd.op = pms_pkg::OP_TICK_POS; state_nxt = S_OUT; end
      S_F0: begin cmd.op = pms_pkg::OP_FORCE_MUL; state_nxt = S_FS; end
      S_FS: begin cmd.op = pms_pkg::OP_DIV_START; state_nxt = S_FD; end
      S_FD: begin
        cmd.op = pms_pkg::OP_DIV_STEP;
        if (status.div_done) state_nxt = S_FA;
      end
      S_FA: begin
        cmd.op = pms_pkg::OP_FORCE_ADD;
        if (axis_r) state_nxt = S_OUT;
        else begin axis_nxt = 1'b1; state_nxt = S_F0; end
      end
      S_C1: if (status.push_small) state_nxt = S_OUT;
        else begin cmd.op = pms_pkg::OP_COL_DOT; state_nxt = S_CD; end
      S_CD: begin
        cmd.op = pms_pkg::OP_DIV_STEP;
        if (status.div_done) state_nxt = S_CP;
      end
      S_CP: begin cmd.op = pms_pkg::OP_COL_PROJ; state_nxt = S_CV; end
      S_CV: begin cmd.op = pms_pkg::OP_COL_VEL; state_nxt = S_OUT; end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r <= 1'b0;
      c_r <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r <= axis_nxt;
      if (in_fire) c_r <= in_cmd;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
endmodule

// ===== hw/rtl/pms_checker.sv =====
// Port-level checker for point_mass_motion_step, bound to the top level.
// Depends on point_mass_motion_step_macros.svh.
`include "point_mass_motion_step_macros.svh"
module pms_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);
  `PMS_ASSERT_IMP(a_excl, clk, rst_n, out_tvalid, !in_tready)
  `PMS_ASSERT_NXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `PMS_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

bind point_mass_motion_step pms_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for point_mass_motion_step: streams command words under random
// stalls and register settings, and checks every state word against a predictor.
// Depends on pms_pkg and the point_mass_motion_step RTL.
module testbench;

  class body_tracker;
    longint drag, friction, bounce, mass, dt, thr;
    longint pos_x, pos_y, vel_x, vel_y;
    bit asleep;
    logic [128:0] state_q[$];
    int errors;
    int checked;

    function new();
      drag = 655; friction = 655; bounce = 65536; mass = 65536; dt = 1092; thr = 1;
      pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0; asleep = 0;
      errors = 0; checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, longint val);
      case (idx)
        pms_pkg::REG_DRAG:     drag = val & 64'h1FFFF;
        pms_pkg::REG_FRICTION: friction = val & 64'h1FFFF;
        pms_pkg::REG_BOUNCE:   bounce = val & 64'h3FFFF;
        pms_pkg::REG_MASS:     mass = val & 64'h7FFFFFFF;
        pms_pkg::REG_DT:       dt = val & 64'h1FFFF;
        pms_pkg::REG_THR:      thr = val & 64'h1FFFF;
        default: ;
      endcase
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function bit [63:0] mag(longint v);
      return (v < 0) ? bit'(0) - 64'(v) : 64'(v);
    endfunction

    function longint one_minus(longint f);
      if (f > pms_pkg::ONE) return 0;
      return pms_pkg::ONE - f;
    endfunction

    function void collide(longint dx, longint dy);
      bit [63:0] pp, thr2, ma, mb, m, q, r;
      bit na, nb, neg;
      longint k, px, py, tx, ty, fr;
      pos_x = sat(pos_x + dx);
      pos_y = sat(pos_y + dy);
      pp = mag(dx) * mag(dx) + mag(dy) * mag(dy);
      thr2 = 64'(thr) * 64'(thr);
      if (pp == 0 || pp < thr2) return;
      na = ((vel_x < 0) != (dx < 0)) && vel_x != 0 && dx != 0;
      nb = ((vel_y < 0) != (dy < 0)) && vel_y != 0 && dy != 0;
      ma = mag(vel_x) * mag(dx);
      mb = mag(vel_y) * mag(dy);
      if (na == nb) begin
        m = ma + mb; neg = na;
      end else if (ma >= mb) begin
        m = ma - mb; neg = na;
      end else begin
        m = mb - ma; neg = nb;
      end
      q = m / pp;
      r = m % pp;
      for (int i = 0; i < pms_pkg::FRAC_BITS; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= pp) begin
          r = r - pp; q[0] = 1'b1;
        end
      end
      k = neg ? -longint'(q) : longint'(q);
      px = (k * dx) >>> pms_pkg::FRAC_BITS;
      py = (k * dy) >>> pms_pkg::FRAC_BITS;
      tx = vel_x - px;
      ty = vel_y - py;
      fr = one_minus(friction);
      vel_x = sat(((tx * fr) >>> pms_pkg::FRAC_BITS) - ((px * bounce) >>> pms_pkg::FRAC_BITS));
      vel_y = sat(((ty * fr) >>> pms_pkg::FRAC_BITS) - ((py * bounce) >>> pms_pkg::FRAC_BITS));
    endfunction

    function void note_input(pms_pkg::cmd_t cmd, logic signed [31:0] x,
                             logic signed [31:0] y);
      longint vx, vy, m, fd;
      bit [63:0] s2, thr2;
      vx = x; vy = y;
      m = (mass != 0) ? mass : 1;
      case (cmd)
        pms_pkg::CMD_TICK: if (!asleep) begin
          fd = one_minus(drag);
          vel_x = (vel_x * fd) >>> pms_pkg::FRAC_BITS;
          vel_y = (vel_y * fd) >>> pms_pkg::FRAC_BITS;
          s2 = mag(vel_x) * mag(vel_x) + mag(vel_y) * mag(vel_y);
          thr2 = 64'(thr) * 64'(thr);
          if (s2 < thr2) begin
            vel_x = 0; vel_y = 0;
          end
          pos_x = sat(pos_x + ((vel_x * dt) >>> pms_pkg::FRAC_BITS));
          pos_y = sat(pos_y + ((vel_y * dt) >>> pms_pkg::FRAC_BITS));
        end
        pms_pkg::CMD_FORCE, pms_pkg::CMD_IMPULSE: begin
          vel_x = sat(vel_x + (vx * dt) / m);
          vel_y = sat(vel_y + (vy * dt) / m);
        end
        pms_pkg::CMD_VEL: begin
          vel_x = sat(vel_x + ((vx * dt) >>> pms_pkg::FRAC_BITS));
          vel_y = sat(vel_y + ((vy * dt) >>> pms_pkg::FRAC_BITS));
        end
        pms_pkg::CMD_COLLIDE: if (!asleep) collide(vx, vy);
        pms_pkg::CMD_SLEEP: asleep = 1;
        pms_pkg::CMD_WAKE: asleep = 0;
        default: ;
      endcase
      state_q.push_back({asleep, vel_y[31:0], vel_x[31:0], pos_y[31:0], pos_x[31:0]});
    endfunction

    function void check(logic [127:0] data, logic user);
      logic [128:0] e;
      if (state_q.size() == 0) begin
        $error("state word with none expected: %h", data);
        errors++;
        return;
      end
      e = state_q.pop_front();
      checked++;
      if (data[31:0] !== e[31:0]) begin
        $error("pos_x expected %0d actual %0d", $signed(e[31:0]), $signed(data[31:0]));
        errors++;
      end
      if (data[63:32] !== e[63:32]) begin
        $error("pos_y expected %0d actual %0d", $signed(e[63:32]), $signed(data[63:32]));
        errors++;
      end
      if (data[95:64] !== e[95:64]) begin
        $error("vel_x expected %0d actual %0d", $signed(e[95:64]), $signed(data[95:64]));
        errors++;
      end
      if (data[127:96] !== e[127:96]) begin
        $error("vel_y expected %0d actual %0d", $signed(e[127:96]), $signed(data[127:96]));
        errors++;
      end
      if (user !== e[128]) begin
        $error("asleep expected %0b actual %0b", e[128], user);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tuser;
  logic [71:0] in_tdata;   // command[2:0], vec_x[34:3], vec_y[66:35], zero pad
  logic [127:0] out_tdata; // pos_x, pos_y, vel_x, vel_y
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  body_tracker body;
  bit steady;
  int words_sent;

  point_mass_motion_step DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAIL point_mass_motion_step");
    $finish;
  end

  always @(negedge clk) out_tready <= steady || ($urandom_range(99) >= 37);

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) body.check(out_tdata, out_tuser);

  task automatic send_word(pms_pkg::cmd_t cmd, logic [31:0] x, logic [31:0] y);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 37) begin
      in_tvalid = 0;
      @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata = {5'd0, y, x, cmd};
    do @(posedge clk); while (!in_tready);
    body.note_input(cmd, x, y);
    words_sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    in_tvalid = 0;
    cfg_psel = 1; cfg_penable = 0; cfg_pwrite = 1;
    cfg_paddr = {idx, 2'b00}; cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1;
    do @(posedge clk); while (!cfg_pready);
    body.set_reg(idx, val);
    @(negedge clk);
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 0;
    while (body.state_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_regs(logic [31:0] d, f, b, m, t, h);
    drain();
    write_reg(pms_pkg::REG_DRAG, d);
    write_reg(pms_pkg::REG_FRICTION, f);
    write_reg(pms_pkg::REG_BOUNCE, b);
    write_reg(pms_pkg::REG_MASS, m);
    write_reg(pms_pkg::REG_DT, t);
    write_reg(pms_pkg::REG_THR, h);
  endtask

  function automatic logic [31:0] pick_vec();
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'($signed($urandom_range(2097151)) - 1048576);
      4, 5, 6: return 32'($signed($urandom_range(134217727)) - 67108864);
      7, 8: return $urandom;
      default: case ($urandom_range(4))
        0: return 32'h80000000;
        1: return 32'h7fffffff;
        2: return 32'hffffffff;
        3: return 32'd1;
        default: return 32'd0;
      endcase
    endcase
  endfunction

  function automatic pms_pkg::cmd_t pick_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 28) return pms_pkg::CMD_TICK;
    if (r < 40) return pms_pkg::CMD_FORCE;
    if (r < 48) return pms_pkg::CMD_IMPULSE;
    if (r < 60) return pms_pkg::CMD_VEL;
    if (r < 64) return pms_pkg::CMD_ACCEL;
    if (r < 84) return pms_pkg::CMD_COLLIDE;
    if (r < 90) return pms_pkg::CMD_SLEEP;
    return pms_pkg::CMD_WAKE;
  endfunction

  task automatic random_words(int n);
    pms_pkg::cmd_t c;
    logic [31:0] x, y;
    for (int i = 0; i < n; i++) begin
      c = pick_cmd();
      x = pick_vec();
      y = pick_vec();
      // small pushes, some below the rest threshold
      if (c == pms_pkg::CMD_COLLIDE && $urandom_range(4) == 0) begin
        x = 32'($signed($urandom_range(600)) - 300);
        y = 32'($signed($urandom_range(600)) - 300);
      end
      send_word(c, x, y);
    end
  endtask

  initial begin
    body = new();
    rst_n = 0; steady = 0; words_sent = 0;
    in_tvalid = 0; in_tdata = '0; out_tready = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: every command, field extremes, sleeping, zero and tiny pushes
    send_word(pms_pkg::CMD_TICK, 0, 0);
    send_word(pms_pkg::CMD_VEL, 32'h7fffffff, 32'h80000000);
    send_word(pms_pkg::CMD_TICK, 0, 0);
    send_word(pms_pkg::CMD_FORCE, 32'h80000000, 32'h7fffffff);
    send_word(pms_pkg::CMD_IMPULSE, 32'h00010000, 32'hffff0000);
    send_word(pms_pkg::CMD_ACCEL, 32'hffffffff, 32'hffffffff);
    send_word(pms_pkg::CMD_COLLIDE, 0, 0);
    send_word(pms_pkg::CMD_COLLIDE, 32'h00010000, 0);
    send_word(pms_pkg::CMD_COLLIDE, 32'h80000000, 32'h80000000);
    send_word(pms_pkg::CMD_COLLIDE, 32'h7fffffff, 32'h7fffffff);
    send_word(pms_pkg::CMD_SLEEP, 0, 0);
    send_word(pms_pkg::CMD_TICK, 0, 0);
    send_word(pms_pkg::CMD_COLLIDE, 32'h00020000, 32'h00030000);
    send_word(pms_pkg::CMD_FORCE, 32'h00100000, 32'h00100000);
    send_word(pms_pkg::CMD_VEL, 32'h00100000, 32'hfff00000);
    send_word(pms_pkg::CMD_WAKE, 0, 0);
    send_word(pms_pkg::CMD_TICK, 0, 0);
    send_word(pms_pkg::CMD_COLLIDE, 32'hfffe0000, 32'h00050000);
    send_word(pms_pkg::CMD_TICK, 0, 0);

    load_regs(0, 0, 0, 0, 1, 0);
    random_words(100);
    load_regs(65536, 65536, 131072, 32'h7fffffff, 65536, 65536);
    random_words(100);
    load_regs(655, 655, 65536, 65536, 1092, 1);
    steady = 1;
    random_words(120);
    steady = 0;
    random_words(80);
    for (int p = 0; p < 5; p++) begin
      load_regs($urandom_range(65536), $urandom_range(65536), $urandom_range(131072),
                ($urandom_range(3) == 0) ? $urandom_range(32'h7fffffff, 0)
                                         : $urandom_range(1 << 22, 1 << 10),
                $urandom_range(65536, 1), $urandom_range(4000));
      random_words(100);
    end

    drain();
    repeat (200) @(posedge clk);
    $display("Sent %0d command words over 8 register settings, checked %0d state words.",
             words_sent, body.checked);
    if (body.errors == 0 && body.state_q.size() == 0)
      $display("PASS point_mass_motion_step");
    else
      $display("FAIL point_mass_motion_step");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pms_pkg.sv
hw/rtl/pms_datapath.sv
hw/rtl/pms_ctrl.sv
hw/rtl/point_mass_motion_step.sv
hw/rtl/pms_checker.sv
test/testbench.sv
